>>> src/mqsp_pkg.sv
`default_nettype none

package mqsp_pkg;

	// Block dimensions
	localparam int NUM_QUEUES  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int KEY_BITS    = 16;

	// Key width actually stored: the age field is 16 bits wide
	localparam int KEY_W = (KEY_BITS < 16) ? KEY_BITS : 16;
	localparam int TAG_W = 16;

	// Derived widths
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int DW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

	// Command queue between front and back
	localparam int FQ_DEPTH = 2;
	localparam int FPW      = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
	localparam int FCW      = $clog2(FQ_DEPTH + 1);

	// Operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_BADQ  = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Classified command handed from front to back
	typedef struct packed {
		logic             func;
		logic             bad;
		logic [QW-1:0]    q;
		logic [KEY_W-1:0] age;
		logic [TAG_W-1:0] tag;
	} item_t;

	// One stored entry
	typedef struct packed {
		logic [KEY_W-1:0] age;
		logic [TAG_W-1:0] tag;
	} cell_t;

endpackage

`default_nettype wire

>>> src/mqsp_front.sv
`default_nettype none

module mqsp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 func,
	input  wire logic [7:0]           queue_number,
	input  wire logic [15:0]          entry_age,
	input  wire logic [15:0]          entry_tag,
	output logic                      item_valid,
	output mqsp_pkg::item_t           item,
	input  wire logic                 item_take
);

	mqsp_pkg::item_t                fq_q [mqsp_pkg::FQ_DEPTH];
	logic [mqsp_pkg::FPW-1:0]       wptr_q;
	logic [mqsp_pkg::FPW-1:0]       rptr_q;
	logic [mqsp_pkg::FCW-1:0]       cnt_q;
	mqsp_pkg::item_t                cls;
	logic                           push;
	logic                           pop;

	// Classify the incoming command
	always_comb begin
		cls.func = func;
		cls.bad  = (queue_number < 8'd1) ||
			(queue_number > 8'(mqsp_pkg::NUM_QUEUES));
		cls.q    = mqsp_pkg::QW'(queue_number - 8'd1);
		cls.age  = entry_age[mqsp_pkg::KEY_W-1:0];
		cls.tag  = entry_tag;
	end

	assign busy       = (cnt_q == mqsp_pkg::FCW'(mqsp_pkg::FQ_DEPTH));
	assign push       = start && !busy;
	assign pop        = item_take && item_valid;
	assign item_valid = (cnt_q != '0);
	assign item       = fq_q[rptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[wptr_q] <= cls;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == mqsp_pkg::FPW'(mqsp_pkg::FQ_DEPTH - 1)) ?
					'0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == mqsp_pkg::FPW'(mqsp_pkg::FQ_DEPTH - 1)) ?
					'0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/mqsp_back.sv
`default_nettype none

module mqsp_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	input  wire mqsp_pkg::item_t      item,
	output logic                      item_take,
	output logic                      done,
	output logic [1:0]                status,
	output logic [15:0]               popped_age,
	output logic [15:0]               popped_tag,
	output logic [4:0]                queue_count
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_RD  = 3'd1;
	localparam logic [2:0] S_INS_CMP = 3'd2;
	localparam logic [2:0] S_POP_RD  = 3'd3;
	localparam logic [2:0] S_POP_WR  = 3'd4;

	// Entry store, all queues side by side
	mqsp_pkg::cell_t               mem [mqsp_pkg::NUM_QUEUES * mqsp_pkg::QUEUE_DEPTH];
	mqsp_pkg::cell_t               rd_q;
	logic                          mem_we;
	logic [mqsp_pkg::AW-1:0]       mem_waddr;
	logic [mqsp_pkg::AW-1:0]       mem_raddr;
	mqsp_pkg::cell_t               mem_wdata;

	logic [2:0]                    st_q;
	logic [mqsp_pkg::CW-1:0]       fill_q [mqsp_pkg::NUM_QUEUES];
	logic [mqsp_pkg::CW-1:0]       i_q;
	logic [mqsp_pkg::CW-1:0]       fill_cur_q;
	logic [mqsp_pkg::QW-1:0]       q_q;
	logic [mqsp_pkg::AW-1:0]       base_q;
	mqsp_pkg::cell_t               new_q;
	mqsp_pkg::cell_t               head_q;
	mqsp_pkg::cell_t               head;
	logic [mqsp_pkg::CW-1:0]       fill_in;
	logic [mqsp_pkg::CW-1:0]       i_dec;
	logic [mqsp_pkg::CW-1:0]       i_inc;
	logic [mqsp_pkg::CW-1:0]       rd_slot;
	logic [mqsp_pkg::CW-1:0]       wr_slot;

	assign item_take = item_valid && (st_q == S_IDLE);
	assign fill_in   = fill_q[item.q];
	assign i_dec     = i_q - 1'b1;
	assign i_inc     = i_q + 1'b1;
	assign head      = (i_q == '0) ? rd_q : head_q;

	// Memory port control
	always_comb begin
		rd_slot   = (st_q == S_INS_RD) ? i_dec : i_q;
		wr_slot   = (st_q == S_POP_WR) ? i_dec : i_q;
		mem_raddr = base_q + mqsp_pkg::AW'(rd_slot[mqsp_pkg::DW-1:0]);
		mem_waddr = base_q + mqsp_pkg::AW'(wr_slot[mqsp_pkg::DW-1:0]);
		mem_we    = 1'b0;
		mem_wdata = new_q;
		case (st_q)
			S_INS_RD: begin
				mem_we = (i_q == '0);
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (!(new_q.age < rd_q.age)) begin
					mem_wdata = rd_q;
				end
			end
			S_POP_WR: begin
				mem_we    = (i_q != '0);
				mem_wdata = rd_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Entry store access, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// Command payload held while it runs
	always_ff @(posedge clk) begin
		if (item_take) begin
			q_q        <= item.q;
			base_q     <= mqsp_pkg::AW'(item.q * mqsp_pkg::QUEUE_DEPTH);
			new_q.age  <= item.age;
			new_q.tag  <= item.tag;
			fill_cur_q <= fill_in;
		end
		if (st_q == S_POP_WR && i_q == '0) begin
			head_q <= rd_q;
		end
	end

	// Sequencer: insert walks from the tail, pop walks from the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			i_q         <= '0;
			done        <= 1'b0;
			status      <= mqsp_pkg::ST_OK;
			popped_age  <= '0;
			popped_tag  <= '0;
			queue_count <= '0;
			for (int k = 0; k < mqsp_pkg::NUM_QUEUES; k++) begin
				fill_q[k] <= '0;
			end
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (item_take) begin
						popped_age <= '0;
						popped_tag <= '0;
						if (item.bad) begin
							done        <= 1'b1;
							status      <= mqsp_pkg::ST_BADQ;
							queue_count <= '0;
						end else if (item.func == mqsp_pkg::FUNC_POP) begin
							if (fill_in == '0) begin
								done        <= 1'b1;
								status      <= mqsp_pkg::ST_EMPTY;
								queue_count <= '0;
							end else begin
								i_q  <= '0;
								st_q <= S_POP_RD;
							end
						end else begin
							if (fill_in >= mqsp_pkg::CW'(mqsp_pkg::QUEUE_DEPTH)) begin
								done        <= 1'b1;
								status      <= mqsp_pkg::ST_FULL;
								queue_count <= 5'(fill_in);
							end else begin
								i_q  <= fill_in;
								st_q <= S_INS_RD;
							end
						end
					end
				end
				S_INS_RD: begin
					if (i_q == '0) begin
						fill_q[q_q] <= fill_cur_q + 1'b1;
						done        <= 1'b1;
						status      <= mqsp_pkg::ST_OK;
						queue_count <= 5'(fill_cur_q + 1'b1);
						st_q        <= S_IDLE;
					end else begin
						st_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (new_q.age < rd_q.age) begin
						fill_q[q_q] <= fill_cur_q + 1'b1;
						done        <= 1'b1;
						status      <= mqsp_pkg::ST_OK;
						queue_count <= 5'(fill_cur_q + 1'b1);
						st_q        <= S_IDLE;
					end else begin
						i_q  <= i_dec;
						st_q <= S_INS_RD;
					end
				end
				S_POP_RD: begin
					st_q <= S_POP_WR;
				end
				S_POP_WR: begin
					if (i_inc == fill_cur_q) begin
						fill_q[q_q] <= fill_cur_q - 1'b1;
						done        <= 1'b1;
						status      <= mqsp_pkg::ST_OK;
						popped_age  <= 16'(head.age);
						popped_tag  <= head.tag;
						queue_count <= 5'(fill_cur_q - 1'b1);
						st_q        <= S_IDLE;
					end else begin
						i_q  <= i_inc;
						st_q <= S_POP_RD;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/multi_queue_sorted_priority_core.sv
`default_nettype none

// A rejected command (bad queue, empty pop, full insert) raises done from the idle
//   state once taken; an insert passes a read and a compare state per entry it moves,
//   a pop a read and a write state per entry that the queue holds.
// Throughput: one command at a time in the back sequencer; a 2-entry command queue
//   takes new commands while one runs, busy rises when it is full. done cannot stall.
// Reset: arst_n clears all queue fills and control; stored entries need no clearing.
module multi_queue_sorted_priority_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [7:0]  queue_number,
	input  wire logic [15:0] entry_age,
	input  wire logic [15:0] entry_tag,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      popped_age,
	output logic [15:0]      popped_tag,
	output logic [4:0]       queue_count
);

	logic            item_valid;
	logic            item_take;
	mqsp_pkg::item_t item;

	// Front: accept and classify
	mqsp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.queue_number (queue_number),
		.entry_age    (entry_age),
		.entry_tag    (entry_tag),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take)
	);

	// Back: run the sorted insert or pop
	mqsp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take),
		.done        (done),
		.status      (status),
		.popped_age  (popped_age),
		.popped_tag  (popped_tag),
		.queue_count (queue_count)
	);

endmodule

`default_nettype wire

>>> src/mqsp_checker.sv
`default_nettype none

module mqsp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        done,
	input  wire logic [1:0]  status,
	input  wire logic [15:0] popped_age,
	input  wire logic [15:0] popped_tag,
	input  wire logic [4:0]  queue_count
);

	// Rejected commands carry no entry
	a_no_entry_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != mqsp_pkg::ST_OK |-> popped_age == '0 && popped_tag == '0)
		else $error("entry data on a rejected command");

	// Bad queue number reports an empty count
	a_badq_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == mqsp_pkg::ST_BADQ |-> queue_count == '0)
		else $error("bad queue result with nonzero count");

	// Empty pop reports an empty count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == mqsp_pkg::ST_EMPTY |-> queue_count == '0)
		else $error("empty pop with nonzero count");

	// Full insert reports the queue depth
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == mqsp_pkg::ST_FULL |->
			queue_count == 5'(mqsp_pkg::QUEUE_DEPTH))
		else $error("full insert with wrong count");

endmodule

bind multi_queue_sorted_priority_core mqsp_checker u_mqsp_checker (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_ITEMS  = 600;

	// One response of the block, field order as on the ports
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] age;
		logic [15:0] tag;
		logic [4:0]  count;
	} resp_t;

	// Shadow copy of the queues plus the list of responses still owed
	class queue_board;
		bit [15:0] key_mem [mqsp_pkg::NUM_QUEUES][mqsp_pkg::QUEUE_DEPTH];
		bit [15:0] tag_mem [mqsp_pkg::NUM_QUEUES][mqsp_pkg::QUEUE_DEPTH];
		int        fill_lvl [mqsp_pkg::NUM_QUEUES];
		resp_t     awaited[$];
		int        mismatches;

		// Apply one accepted command to the shadow queues, queue its response
		function void note_command(logic op, logic [7:0] qn, logic [15:0] age,
			logic [15:0] tag);
			resp_t     r;
			int        q;
			int        pos;
			int        i;
			bit [15:0] key;
			r = '0;
			key = age & 16'((32'd1 << mqsp_pkg::KEY_W) - 1);
			if (qn == 8'd0 || qn > mqsp_pkg::NUM_QUEUES) begin
				r.status = mqsp_pkg::ST_BADQ;
			end else begin
				q = int'(qn) - 1;
				if (op == mqsp_pkg::FUNC_POP) begin
					if (fill_lvl[q] == 0) begin
						r.status = mqsp_pkg::ST_EMPTY;
					end else begin
						r.status = mqsp_pkg::ST_OK;
						r.age = key_mem[q][0];
						r.tag = tag_mem[q][0];
						for (i = 0; i + 1 < fill_lvl[q]; i++) begin
							key_mem[q][i] = key_mem[q][i + 1];
							tag_mem[q][i] = tag_mem[q][i + 1];
						end
						fill_lvl[q]--;
						r.count = 5'(fill_lvl[q]);
					end
				end else if (fill_lvl[q] >= mqsp_pkg::QUEUE_DEPTH) begin
					r.status = mqsp_pkg::ST_FULL;
					r.count = 5'(fill_lvl[q]);
				end else begin
					// new entry goes ahead of the first key that is not greater
					pos = 0;
					while (pos < fill_lvl[q] && key < key_mem[q][pos])
						pos++;
					for (i = fill_lvl[q]; i > pos; i--) begin
						key_mem[q][i] = key_mem[q][i - 1];
						tag_mem[q][i] = tag_mem[q][i - 1];
					end
					key_mem[q][pos] = key;
					tag_mem[q][pos] = tag;
					fill_lvl[q]++;
					r.status = mqsp_pkg::ST_OK;
					r.count = 5'(fill_lvl[q]);
				end
			end
			awaited = {awaited, r};
		endfunction

		// Compare one response with the oldest one owed
		function void check_response(resp_t got);
			resp_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: stray response: status %0d age %h tag %h count %0d",
						$realtime, got.status, got.age, got.tag, got.count);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: status %0d/%0d age %h/%h tag %h/%h count %0d/%0d (exp/act)",
						$realtime, want.status, got.status, want.age, got.age,
						want.tag, got.tag, want.count, got.count);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        func = mqsp_pkg::FUNC_INSERT;
	logic [7:0]  queue_number = 8'd0;
	logic [15:0] entry_age = 16'd0;
	logic [15:0] entry_tag = 16'd0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [15:0] popped_age;
	logic [15:0] popped_tag;
	logic [4:0]  queue_count;

	queue_board board;
	int         idle_pct = 0;
	int         cycles = 0;

	multi_queue_sorted_priority_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.queue_number (queue_number),
		.entry_age    (entry_age),
		.entry_tag    (entry_tag),
		.done         (done),
		.status       (status),
		.popped_age   (popped_age),
		.popped_tag   (popped_tag),
		.queue_count  (queue_count)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Command and response monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_command(func, queue_number, entry_age, entry_tag);
			if (done)
				board.check_response({status, popped_age, popped_tag, queue_count});
		end
	end

	// Issue one command, with an optional idle gap in front; returns after the transfer
	task automatic send_cmd(logic op, logic [7:0] qn, logic [15:0] age, logic [15:0] tag);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		func = op;
		queue_number = qn;
		entry_age = age;
		entry_tag = tag;
		do @(posedge clk); while (busy);
	endtask

	// Random traffic in segments: each segment has its own insert bias and queue spread
	task automatic run_random(int n);
		int         taken;
		int         k;
		int         bias;
		int         lo;
		int         hi;
		int         pick;
		logic       op;
		logic [7:0] qn;
		logic [15:0] age;
		taken = 0;
		k = 0;
		bias = 50;
		lo = 1;
		hi = mqsp_pkg::NUM_QUEUES;
		while (taken < n) begin
			if (k % 60 == 0) begin
				case ($urandom_range(3))
					0: bias = 10;
					1: bias = 45;
					2: bias = 70;
					default: bias = 95;
				endcase
				pick = $urandom_range(2);
				if (pick == 0) begin
					lo = $urandom_range(1, mqsp_pkg::NUM_QUEUES);
					hi = lo;
				end else if (pick == 1) begin
					lo = $urandom_range(1, (mqsp_pkg::NUM_QUEUES > 1) ?
						mqsp_pkg::NUM_QUEUES - 1 : 1);
					hi = (mqsp_pkg::NUM_QUEUES > 1) ? lo + 1 : lo;
				end else begin
					lo = 1;
					hi = mqsp_pkg::NUM_QUEUES;
				end
			end
			k++;
			op = ($urandom_range(99) < bias) ? mqsp_pkg::FUNC_INSERT : mqsp_pkg::FUNC_POP;
			// a few out-of-range queue numbers
			if ($urandom_range(99) < 5) begin
				qn = $urandom_range(1) ? 8'd0 :
					8'($urandom_range(mqsp_pkg::NUM_QUEUES + 1, 255));
			end else begin
				qn = 8'($urandom_range(lo, hi));
				taken++;
			end
			// narrow keys give many ties
			pick = $urandom_range(99);
			if (pick < 25)
				age = 16'($urandom_range(0, 7));
			else if (pick < 35)
				age = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			else
				age = 16'($urandom);
			send_cmd(op, qn, age, 16'($urandom));
		end
	endtask

	initial begin
		board = new;
		idle_pct = 24;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// bad queue numbers, empty pop
		send_cmd(mqsp_pkg::FUNC_INSERT, 8'd0, 16'hFFFF, 16'hFFFF);
		send_cmd(mqsp_pkg::FUNC_POP, 8'd255, 16'h0000, 16'h0000);
		send_cmd(mqsp_pkg::FUNC_INSERT, 8'(mqsp_pkg::NUM_QUEUES + 1), 16'h1234, 16'h0001);
		send_cmd(mqsp_pkg::FUNC_POP, 8'd1, 16'h0000, 16'h0000);
		// key and tag extremes at first and last queue
		send_cmd(mqsp_pkg::FUNC_INSERT, 8'd1, 16'hFFFF, 16'hFFFF);
		send_cmd(mqsp_pkg::FUNC_INSERT, 8'(mqsp_pkg::NUM_QUEUES), 16'h0000, 16'h0000);
		// equal keys: newest leaves first
		send_cmd(mqsp_pkg::FUNC_INSERT, 8'd2, 16'h8080, 16'hA001);
		send_cmd(mqsp_pkg::FUNC_INSERT, 8'd2, 16'h8080, 16'hA002);
		send_cmd(mqsp_pkg::FUNC_INSERT, 8'd2, 16'h0100, 16'hA003);
		send_cmd(mqsp_pkg::FUNC_INSERT, 8'd2, 16'hFF00, 16'hA004);
		repeat (4) send_cmd(mqsp_pkg::FUNC_POP, 8'd2, 16'h0000, 16'h0000);
		send_cmd(mqsp_pkg::FUNC_POP, 8'd1, 16'h0000, 16'h0000);
		send_cmd(mqsp_pkg::FUNC_POP, 8'(mqsp_pkg::NUM_QUEUES), 16'h0000, 16'h0000);
		// fill one queue past its depth
		repeat (mqsp_pkg::QUEUE_DEPTH + 1)
			send_cmd(mqsp_pkg::FUNC_INSERT, 8'd3, 16'($urandom_range(0, 3)),
				16'($urandom));

		run_random(PHASE_ITEMS);
		idle_pct = 71;
		run_random(PHASE_ITEMS);
		idle_pct = 0;
		run_random(PHASE_ITEMS);
		@(negedge clk);
		start = 1'b0;

		// drain, then give stray responses a chance to show
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> sim.f
src/mqsp_pkg.sv
src/mqsp_front.sv
src/mqsp_back.sv
src/multi_queue_sorted_priority_core.sv
src/mqsp_checker.sv
tb/sv/testbench.sv
